@@ src/pdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared widths, entry layout, action codes and memory control for the
// paired device table.
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TR_W    = 2;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_LOAD   = 3'd1,
    ACT_ADD    = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_LOOKUP = 3'd4,
    ACT_GET    = 3'd5
  } action_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TR_W-1:0]   transport;
    logic [TAG_W-1:0]  name_tag;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

@@ src/pdt_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_ifs
// Request and result channels of the paired device table, valid/ready.
// ----------------------------------------------------------------------------
interface pdt_in_if;
  logic                       valid;
  logic                       ready;
  logic [pdt_pkg::ACT_W-1:0]  action;
  logic [pdt_pkg::ADDR_W-1:0] device_addr;
  logic [pdt_pkg::TR_W-1:0]   transport_mask;
  logic [pdt_pkg::TAG_W-1:0]  name_tag;
  logic [pdt_pkg::SLOT_W-1:0] slot_index;

  modport source (
    output valid, action, device_addr, transport_mask, name_tag, slot_index,
    input  ready
  );
  modport sink (
    input  valid, action, device_addr, transport_mask, name_tag, slot_index,
    output ready
  );
endinterface

interface pdt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [pdt_pkg::ADDR_W-1:0]  entry_addr;
  logic [pdt_pkg::TR_W-1:0]    entry_transport;
  logic [pdt_pkg::TAG_W-1:0]   entry_name_tag;
  logic [pdt_pkg::COUNT_W-1:0] entry_count;
  logic                        changed_flag;

  modport source (
    output valid, success, entry_addr, entry_transport, entry_name_tag,
           entry_count, changed_flag,
    input  ready
  );
  modport sink (
    input  valid, success, entry_addr, entry_transport, entry_name_tag,
           entry_count, changed_flag,
    output ready
  );
endinterface

@@ src/paired_device_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_device_table
// Keyed table of paired devices: clear, load, add/merge, remove, lookup and
// get by index over entries held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  in_ch     sink       request: action, device_addr, transport_mask,
//                       name_tag, slot_index
//  out_ch    source     result: success, entry fields, entry_count,
//                       changed_flag
//
// one request at a time; clear, load and the unused codes need no memory read,
// get reads one entry, and add, remove and lookup scan the held entries one
// memory read per cycle (remove then reads the last entry for the freed slot).
// synchronous reset empties the table at once; entry contents are not cleared.
// a result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module paired_device_table #(
  parameter int unsigned ENTRIES = pdt_pkg::ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pdt_in_if.sink    in_ch,
  pdt_out_if.source out_ch
);
  import pdt_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  entry_t           mem_rd_data;

  pdt_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  pdt_mem #(
    .DEPTH (ENTRIES)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

endmodule

@@ src/pdt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pdt_mem #(
  parameter int unsigned DEPTH = pdt_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  pdt_pkg::mem_ctl_t ctl,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  input  pdt_pkg::entry_t   wr_data,
  output pdt_pkg::entry_t   rd_data
);
  import pdt_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/pdt_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_engine
// Request sequencer: linear search, read-modify-write of entries, count and
// dirty flag, and the result register.
// ----------------------------------------------------------------------------
module pdt_engine #(
  parameter int unsigned ENTRIES = pdt_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  pdt_in_if.sink            in_ch,
  pdt_out_if.source         out_ch,
  output pdt_pkg::mem_ctl_t mem_ctl,
  output logic [IDX_W-1:0]  mem_rd_addr,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output pdt_pkg::entry_t   mem_wr_data,
  input  pdt_pkg::entry_t   mem_rd_data
);
  import pdt_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SEARCH, S_REMOVE, S_GET, S_DONE
  } state_t;

  state_t state_r;

  // latched request
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TR_W-1:0]   tr_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SLOT_W-1:0] slot_r;

  logic [CNT_W-1:0]  count_r;
  logic              dirty_r;
  logic [CNT_W-1:0]  issue_k_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_k_r;
  logic [IDX_W-1:0]  hit_k_r;

  logic              res_ok_r;
  entry_t            res_ent_r;

  logic              out_valid_r;
  logic              out_ok_r;
  entry_t            out_ent_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic              out_dirty_r;

  logic              hit;
  logic              more;
  logic              room;
  logic              idx_ok;
  logic              changed;
  logic              res_load;
  logic [TR_W-1:0]   merged_tr;
  logic [TAG_W-1:0]  merged_tag;
  logic [CNT_W-1:0]  last_k;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  entry_t            req_ent;

  assign req_ent    = '{addr: addr_r, transport: tr_r, name_tag: tag_r};
  assign hit        = pend_r && (mem_rd_data.addr == addr_r);
  assign more       = issue_k_r < count_r;
  assign room       = count_r < CNT_W'(ENTRIES);
  assign idx_ext    = CMP_W'(slot_r);
  assign cnt_ext    = CMP_W'(count_r);
  assign idx_ok     = idx_ext < cnt_ext;
  assign last_k     = count_r - CNT_W'(1);
  assign merged_tr  = mem_rd_data.transport | tr_r;
  // an empty stored name takes a given nonzero name
  assign merged_tag = (tag_r != '0 && mem_rd_data.name_tag == '0) ? tag_r
                                                                   : mem_rd_data.name_tag;
  assign changed    = (merged_tr != mem_rd_data.transport) ||
                      (merged_tag != mem_rd_data.name_tag);
  assign res_load   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mem_ctl     = '0;
    mem_rd_addr = '0;
    mem_wr_addr = '0;
    mem_wr_data = req_ent;
    unique case (state_r)
      S_EXEC: begin
        if (act_r == ACT_LOAD && tr_r != '0 && room) begin
          mem_ctl.wr_en = 1'b1;
          mem_wr_addr   = count_r[IDX_W-1:0];
        end
        if (act_r == ACT_GET && idx_ok) begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = idx_ext[IDX_W-1:0];
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (act_r == ACT_ADD) begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = pend_k_r;
            mem_wr_data   = '{addr: mem_rd_data.addr, transport: merged_tr,
                              name_tag: merged_tag};
          end
          if (act_r == ACT_REMOVE) begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = last_k[IDX_W-1:0];
          end
        end else if (more) begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = issue_k_r[IDX_W-1:0];
        end else if (act_r == ACT_ADD && room) begin
          mem_ctl.wr_en = 1'b1;
          mem_wr_addr   = count_r[IDX_W-1:0];
        end
      end
      S_REMOVE: begin
        // last entry moves into the freed slot
        mem_ctl.wr_en = 1'b1;
        mem_wr_addr   = hit_k_r;
        mem_wr_data   = mem_rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dirty_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            act_r   <= in_ch.action;
            addr_r  <= in_ch.device_addr;
            tr_r    <= in_ch.transport_mask;
            tag_r   <= in_ch.name_tag;
            slot_r  <= in_ch.slot_index;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_ent_r <= '0;
          unique case (act_r)
            ACT_CLEAR: begin
              count_r  <= '0;
              dirty_r  <= 1'b0;
              res_ok_r <= 1'b1;
              state_r  <= S_DONE;
            end
            ACT_LOAD: begin
              if (tr_r != '0 && room) begin
                count_r  <= count_r + CNT_W'(1);
                res_ok_r <= 1'b1;
              end else begin
                res_ok_r <= 1'b0;
              end
              state_r <= S_DONE;
            end
            ACT_ADD, ACT_REMOVE, ACT_LOOKUP: begin
              res_ok_r  <= 1'b0;
              issue_k_r <= '0;
              pend_r    <= 1'b0;
              state_r   <= S_SEARCH;
            end
            ACT_GET: begin
              res_ok_r <= 1'b0;
              state_r  <= idx_ok ? S_GET : S_DONE;
            end
            default: begin
              res_ok_r <= 1'b0;
              state_r  <= S_DONE;
            end
          endcase
        end
        S_SEARCH: begin
          if (hit) begin
            pend_r <= 1'b0;
            priority if (act_r == ACT_ADD) begin
              if (changed) begin
                dirty_r <= 1'b1;
              end
              state_r <= S_DONE;
            end else if (act_r == ACT_REMOVE) begin
              hit_k_r <= pend_k_r;
              state_r <= S_REMOVE;
            end else begin
              res_ok_r <= 1'b1;
              state_r  <= S_DONE;
            end
          end else if (more) begin
            pend_r    <= 1'b1;
            pend_k_r  <= issue_k_r[IDX_W-1:0];
            issue_k_r <= issue_k_r + CNT_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (act_r == ACT_ADD && room) begin
              count_r  <= count_r + CNT_W'(1);
              dirty_r  <= 1'b1;
              res_ok_r <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_REMOVE: begin
          count_r  <= last_k;
          dirty_r  <= 1'b1;
          res_ok_r <= 1'b1;
          state_r  <= S_DONE;
        end
        S_GET: begin
          res_ent_r <= mem_rd_data;
          res_ok_r  <= 1'b1;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_ok_r    <= res_ok_r;
            out_ent_r   <= res_ent_r;
            out_cnt_r   <= COUNT_W'(count_r);
            out_dirty_r <= dirty_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.success         = out_ok_r;
  assign out_ch.entry_addr      = out_ent_r.addr;
  assign out_ch.entry_transport = out_ent_r.transport;
  assign out_ch.entry_name_tag  = out_ent_r.name_tag;
  assign out_ch.entry_count     = out_cnt_r;
  assign out_ch.changed_flag    = out_dirty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_ctl.wr_en)
    else $error("memory write with no request in progress");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_EXEC))
    else $error("accepted request not decoded");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMOVE) |=> (count_r == $past(last_k)))
    else $error("remove did not drop the count by one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && mem_ctl.rd_en && !hit) |-> (issue_k_r < count_r))
    else $error("search read beyond held entries");

endmodule
